// ===== rtl/scba_pkg.sv =====
// Shared constants, types and helper functions of the size-class block allocator.
`default_nettype none

package scba_pkg;

   localparam int MAX_LENGTH      = 4096;
   localparam int CLASS_STEP      = 64;
   localparam int CHAR_BYTES      = 4;
   localparam int NUM_DESCRIPTORS = 1024;

   localparam int NUM_CLASSES = (MAX_LENGTH + CLASS_STEP - 1) / CLASS_STEP + 1;
   localparam int BLOCK_BYTES = CLASS_STEP * CHAR_BYTES;

   localparam int CMD_W    = 2;
   localparam int LEN_W    = 13;
   localparam int HANDLE_W = 10;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = HANDLE_W + 1;
   localparam int CLASS_W  = $clog2(NUM_CLASSES);

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [LINK_W-1:0]   link_type;
   typedef logic [CLASS_W-1:0]  class_type;

   localparam link_type NULL_DESC = LINK_W'(NUM_DESCRIPTORS);

   localparam cmd_type CMD_ALLOC   = CMD_W'(0);
   localparam cmd_type CMD_RELEASE = CMD_W'(1);
   localparam cmd_type CMD_RESIZE  = CMD_W'(2);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LONG  = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   // Write requests into the descriptor store, one port per memory
   typedef struct packed {
      logic       link_we;
      handle_type link_wa;
      link_type   link_wd;
      logic       base_we;
      handle_type base_wa;
      addr_type   base_wd;
      logic       len_we;
      handle_type len_wa;
      len_type    len_wd;
   } desc_wr_type;

   typedef struct packed {
      handle_type link_ra;
      handle_type base_ra;
      handle_type len_ra;
   } desc_rd_type;

   // Round up to the class step; saturate at the top class
   function automatic class_type class_of(len_type len);
      logic [LEN_W:0] sum;
      logic [LEN_W:0] quo;
      sum = {1'b0, len} + (LEN_W+1)'(CLASS_STEP - 1);
      quo = (LEN_W+1)'(sum / CLASS_STEP);
      if (quo > (LEN_W+1)'(NUM_CLASSES - 1)) begin
         quo = (LEN_W+1)'(NUM_CLASSES - 1);
      end
      return CLASS_W'(quo);
   endfunction

   function automatic addr_type class_bytes(class_type cls);
      return ADDR_W'(cls) * ADDR_W'(BLOCK_BYTES);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scba_if.sv =====
// Request and response channel interfaces of the size-class block allocator.
`default_nettype none

interface scba_req_if;
   logic                     valid;
   logic                     ready;
   logic [scba_pkg::CMD_W-1:0]    command;
   logic [scba_pkg::LEN_W-1:0]    length;
   logic [scba_pkg::HANDLE_W-1:0] handle;

   modport source (output valid, output command, output length, output handle,
                   input ready);
   modport sink   (input valid, input command, input length, input handle,
                   output ready);
endinterface

interface scba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scba_pkg::HANDLE_W-1:0] result_handle;
   logic [scba_pkg::ADDR_W-1:0]   block_address;
   logic [scba_pkg::STATUS_W-1:0] status;

   modport source (output valid, output result_handle, output block_address,
                   output status, input ready);
   modport sink   (input valid, input result_handle, input block_address,
                   input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/scba_desc_store.sv =====
// Descriptor store: link, base address and length memories with registered reads.
`default_nettype none

module scba_desc_store (
   input  logic                  clock,
   input  scba_pkg::desc_wr_type wr,
   input  scba_pkg::desc_rd_type rd,
   output scba_pkg::link_type    link_q,
   output scba_pkg::addr_type    base_q,
   output scba_pkg::len_type     len_q
);
   import scba_pkg::*;

   link_type link_mem [NUM_DESCRIPTORS];
   addr_type base_mem [NUM_DESCRIPTORS];
   len_type  len_mem  [NUM_DESCRIPTORS];

   link_type link_q_ff;
   addr_type base_q_ff;
   len_type  len_q_ff;

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.link_wa] <= wr.link_wd;
      end
      link_q_ff <= link_mem[rd.link_ra];
   end

   always_ff @(posedge clock) begin
      if (wr.base_we) begin
         base_mem[wr.base_wa] <= wr.base_wd;
      end
      base_q_ff <= base_mem[rd.base_ra];
   end

   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr.len_wa] <= wr.len_wd;
      end
      len_q_ff <= len_mem[rd.len_ra];
   end

   assign link_q = link_q_ff;
   assign base_q = base_q_ff;
   assign len_q  = len_q_ff;

endmodule

`default_nettype wire

// ===== rtl/size_class_block_allocator_unit.sv =====
// Sequence: errors, fresh allocate and same-class resize finish in S_LOOK; a free-list allocate
// goes on through S_ALLOC_POP, release through S_RELEASE, and a class-changing resize through
// S_MOVE and, if it pops a free block, S_MOVE_POP. One transaction at a time: the next is taken
// once the unit is back in S_IDLE, paced by the dependent reads of the class head and descriptor memories.
// Reset: synchronous; clears the state, response valid, class head valid bits, fresh count and bump address at once.
// The descriptor memories are not cleared and hold garbage until written.
`default_nettype none

module size_class_block_allocator_unit (
   input logic       clock,
   input logic       reset,
   scba_req_if.sink   req_ch,
   scba_rsp_if.source rsp_ch
);
   import scba_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_ALLOC_POP,
      S_RELEASE,
      S_MOVE,
      S_MOVE_POP,
      S_HOLD
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   len_type    len_ff, len_in;
   handle_type hdl_ff, hdl_in;
   class_type  cls_ff, cls_in;
   class_type  oldc_ff, oldc_in;
   link_type   hd_ff, hd_in;
   addr_type   ob_ff, ob_in;
   link_type   nx_ff, nx_in;
   addr_type   addr_ff, addr_in;
   link_type   fresh_ff, fresh_in;
   addr_type   next_addr_ff, next_addr_in;

   logic       rsp_valid_ff, rsp_valid_in;
   handle_type rsp_handle_ff, rsp_handle_in;
   addr_type   rsp_addr_ff, rsp_addr_in;
   status_type rsp_status_ff, rsp_status_in;
   handle_type pend_handle_ff, pend_handle_in;
   addr_type   pend_addr_ff, pend_addr_in;
   status_type pend_status_ff, pend_status_in;

   // Class head table
   link_type  head_mem [NUM_CLASSES];
   logic      head_vld_ff [NUM_CLASSES];
   link_type  head_q_ff;
   logic      head_qv_ff;
   class_type head_ra;
   logic      head_we;
   class_type head_wa;
   link_type  head_wd;
   link_type  head_val;

   desc_wr_type desc_wr;
   desc_rd_type desc_rd;
   link_type    link_q;
   addr_type    base_q;
   len_type     len_q;

   logic       accept;
   logic       out_free;
   logic       fin;
   handle_type fin_handle;
   addr_type   fin_addr;
   status_type fin_status;
   logic       len_bad;
   logic       fresh_ok;
   class_type  oldc;
   handle_type fresh_idx;
   link_type   nx_raw;

   scba_desc_store u_desc (
      .clock  (clock),
      .wr     (desc_wr),
      .rd     (desc_rd),
      .link_q (link_q),
      .base_q (base_q),
      .len_q  (len_q)
   );

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q_ff  <= head_mem[head_ra];
      head_qv_ff <= head_vld_ff[head_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_vld_ff[i] <= 1'b0;
         end
      end else if (head_we) begin
         head_vld_ff[head_wa] <= 1'b1;
      end
   end

   assign head_val  = head_qv_ff ? head_q_ff : NULL_DESC;
   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign len_bad   = len_ff > LEN_W'(MAX_LENGTH);
   assign fresh_ok  = fresh_ff < LINK_W'(NUM_DESCRIPTORS);
   assign oldc      = class_of(len_q);
   assign fresh_idx = fresh_ff[HANDLE_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      hdl_in         = hdl_ff;
      cls_in         = cls_ff;
      oldc_in        = oldc_ff;
      hd_in          = hd_ff;
      ob_in          = ob_ff;
      nx_in          = nx_ff;
      addr_in        = addr_ff;
      fresh_in       = fresh_ff;
      next_addr_in   = next_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_handle_in  = rsp_handle_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      pend_handle_in = pend_handle_ff;
      pend_addr_in   = pend_addr_ff;
      pend_status_in = pend_status_ff;

      head_ra = cls_ff;
      head_we = 1'b0;
      head_wa = cls_ff;
      head_wd = NULL_DESC;
      desc_wr = '0;
      desc_rd = '{link_ra: hdl_ff, base_ra: hdl_ff, len_ra: hdl_ff};
      nx_raw  = link_q;

      fin        = 1'b0;
      fin_handle = '0;
      fin_addr   = '0;
      fin_status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            head_ra = class_of(req_ch.length);
            desc_rd = '{link_ra: req_ch.handle, base_ra: req_ch.handle,
                        len_ra: req_ch.handle};
            if (accept) begin
               cmd_in   = req_ch.command;
               len_in   = req_ch.length;
               hdl_in   = req_ch.handle;
               cls_in   = class_of(req_ch.length);
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            ob_in   = base_q;
            oldc_in = oldc;
            hd_in   = head_val;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (len_bad) begin
                     fin        = 1'b1;
                     fin_status = ST_TOO_LONG;
                  end else if (head_val < NULL_DESC) begin
                     desc_rd.link_ra = head_val[HANDLE_W-1:0];
                     desc_rd.base_ra = head_val[HANDLE_W-1:0];
                     state_in        = S_ALLOC_POP;
                  end else if (fresh_ok) begin
                     desc_wr.base_we = 1'b1;
                     desc_wr.base_wa = fresh_idx;
                     desc_wr.base_wd = next_addr_ff;
                     desc_wr.len_we  = 1'b1;
                     desc_wr.len_wa  = fresh_idx;
                     desc_wr.len_wd  = len_ff;
                     fresh_in        = fresh_ff + LINK_W'(1);
                     next_addr_in    = next_addr_ff + class_bytes(cls_ff);
                     fin             = 1'b1;
                     fin_handle      = fresh_idx;
                     fin_addr        = next_addr_ff;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ST_EXHAUSTED;
                  end
               end
               CMD_RELEASE: begin
                  head_ra  = oldc;
                  state_in = S_RELEASE;
               end
               CMD_RESIZE: begin
                  if (len_bad) begin
                     fin        = 1'b1;
                     fin_handle = hdl_ff;
                     fin_addr   = base_q;
                     fin_status = ST_TOO_LONG;
                  end else if (cls_ff == oldc) begin
                     desc_wr.len_we = 1'b1;
                     desc_wr.len_wa = hdl_ff;
                     desc_wr.len_wd = len_ff;
                     fin            = 1'b1;
                     fin_handle     = hdl_ff;
                     fin_addr       = base_q;
                  end else if (!(head_val < NULL_DESC) && !fresh_ok) begin
                     fin        = 1'b1;
                     fin_status = ST_EXHAUSTED;
                  end else begin
                     head_ra         = oldc;
                     desc_rd.link_ra = head_val[HANDLE_W-1:0];
                     desc_rd.base_ra = head_val[HANDLE_W-1:0];
                     state_in        = S_MOVE;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         S_ALLOC_POP: begin
            head_we        = 1'b1;
            head_wa        = cls_ff;
            head_wd        = (link_q < NULL_DESC) ? link_q : NULL_DESC;
            desc_wr.len_we = 1'b1;
            desc_wr.len_wa = hd_ff[HANDLE_W-1:0];
            desc_wr.len_wd = len_ff;
            fin            = 1'b1;
            fin_handle     = hd_ff[HANDLE_W-1:0];
            fin_addr       = base_q;
         end

         S_RELEASE: begin
            desc_wr.link_we = 1'b1;
            desc_wr.link_wa = hdl_ff;
            desc_wr.link_wd = head_val;
            head_we         = 1'b1;
            head_wa         = oldc_ff;
            head_wd         = {1'b0, hdl_ff};
            fin             = 1'b1;
            fin_handle      = hdl_ff;
            fin_addr        = ob_ff;
         end

         S_MOVE: begin
            // push the old block onto its class list
            desc_wr.link_we = 1'b1;
            desc_wr.link_wa = hdl_ff;
            desc_wr.link_wd = head_val;
            head_we         = 1'b1;
            head_wa         = oldc_ff;
            head_wd         = {1'b0, hdl_ff};
            if (hd_ff < NULL_DESC) begin
               // forward the link just written when popping the same descriptor
               if (hd_ff[HANDLE_W-1:0] == hdl_ff) begin
                  nx_raw = head_val;
               end
               nx_in    = (nx_raw < NULL_DESC) ? nx_raw : NULL_DESC;
               addr_in  = base_q;
               state_in = S_MOVE_POP;
            end else begin
               desc_wr.base_we = 1'b1;
               desc_wr.base_wa = fresh_idx;
               desc_wr.base_wd = next_addr_ff;
               desc_wr.len_we  = 1'b1;
               desc_wr.len_wa  = fresh_idx;
               desc_wr.len_wd  = len_ff;
               fresh_in        = fresh_ff + LINK_W'(1);
               next_addr_in    = next_addr_ff + class_bytes(cls_ff);
               fin             = 1'b1;
               fin_handle      = fresh_idx;
               fin_addr        = next_addr_ff;
            end
         end

         S_MOVE_POP: begin
            head_we        = 1'b1;
            head_wa        = cls_ff;
            head_wd        = nx_ff;
            desc_wr.len_we = 1'b1;
            desc_wr.len_wa = hd_ff[HANDLE_W-1:0];
            desc_wr.len_wd = len_ff;
            fin            = 1'b1;
            fin_handle     = hd_ff[HANDLE_W-1:0];
            fin_addr       = addr_ff;
         end

         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = pend_handle_ff;
               rsp_addr_in   = pend_addr_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // deliver the result, or park it until the output register drains
      if (fin) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_handle_in = fin_handle;
            rsp_addr_in   = fin_addr;
            rsp_status_in = fin_status;
            state_in      = S_IDLE;
         end else begin
            pend_handle_in = fin_handle;
            pend_addr_in   = fin_addr;
            pend_status_in = fin_status;
            state_in       = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      len_ff         <= len_in;
      hdl_ff         <= hdl_in;
      cls_ff         <= cls_in;
      oldc_ff        <= oldc_in;
      hd_ff          <= hd_in;
      ob_ff          <= ob_in;
      nx_ff          <= nx_in;
      addr_ff        <= addr_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_status_ff  <= rsp_status_in;
      pend_handle_ff <= pend_handle_in;
      pend_addr_ff   <= pend_addr_in;
      pend_status_ff <= pend_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= '0;
         next_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
         next_addr_ff <= next_addr_in;
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.block_address = rsp_addr_ff;
   assign rsp_ch.status        = rsp_status_ff;

endmodule

`default_nettype wire
